// File: src/xsf_pkg.sv
// ----------------------------------------------------------------------------
// xsf_pkg
// Shared types and codes for the XOR sprite framebuffer: command codes,
// result kinds and the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package xsf_pkg;

  // payload field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned ROW_W    = 4;
  localparam int unsigned SPRITE_W = 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_DRAW  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_e;

  // result kinds
  localparam logic RES_COLLISION = 1'b0;
  localparam logic RES_PIXEL     = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic accept;  // latch the item and start the row read
    logic commit;  // perform the operation on the fetched row
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic result_pending;  // latched command produces a result beat
    logic out_hold;        // output register full and not taken this cycle
  } sts_t;

endpackage

// File: src/xsf_if.sv
// ----------------------------------------------------------------------------
// xsf_in_if / xsf_out_if
// Valid/ready channels of the framebuffer: command beats in, result beats out.
// ----------------------------------------------------------------------------
interface xsf_in_if;
  logic                          valid;
  logic                          ready;
  logic [xsf_pkg::CMD_W-1:0]     cmd;
  logic [xsf_pkg::POS_W-1:0]     x_pos;
  logic [xsf_pkg::POS_W-1:0]     y_pos;
  logic [xsf_pkg::ROW_W-1:0]     row_offset;
  logic [xsf_pkg::SPRITE_W-1:0]  sprite_row;
  logic                          last_row;
  logic                          pixel_value;

  modport source (output valid, cmd, x_pos, y_pos, row_offset, sprite_row,
                  last_row, pixel_value, input ready);
  modport sink   (input valid, cmd, x_pos, y_pos, row_offset, sprite_row,
                  last_row, pixel_value, output ready);
  modport monitor (input valid, ready, cmd, x_pos, y_pos, row_offset, sprite_row,
                   last_row, pixel_value);
endinterface

interface xsf_out_if;
  logic valid;
  logic ready;
  logic result_kind;
  logic collision;
  logic pixel_bit;

  modport source (output valid, result_kind, collision, pixel_bit, input ready);
  modport sink   (input valid, result_kind, collision, pixel_bit, output ready);
endinterface

// File: src/xsf_ram.sv
// ----------------------------------------------------------------------------
// xsf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xsf_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/xsf_ctrl.sv
// ----------------------------------------------------------------------------
// xsf_ctrl
// Two-state sequencer: take a command beat and fetch its row, then commit the
// row update and hand the result to the output register.
// ----------------------------------------------------------------------------
module xsf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  xsf_pkg::sts_t  sts_i,
  output xsf_pkg::ctrl_t ctl_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // next state and commands
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    ctl_o.accept = 1'b0;
    ctl_o.commit = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        ctl_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait only when a result is due and the output register is stuck
        if (!(sts_i.result_pending && sts_i.out_hold)) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/xsf_dpath.sv
// ----------------------------------------------------------------------------
// xsf_dpath
// Framebuffer datapath: coordinate wrap, row memory with per-row valid bits,
// sprite mask and XOR update, collision flag and the output register.
// ----------------------------------------------------------------------------
module xsf_dpath #(
  parameter int unsigned SCREEN_WIDTH    = 64,
  parameter int unsigned SCREEN_HEIGHT   = 32,
  parameter int unsigned MAX_SPRITE_ROWS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  xsf_in_if.sink          in_i,
  xsf_out_if.source       out_o,
  input  xsf_pkg::ctrl_t  ctl_i,
  output xsf_pkg::sts_t   sts_o
);

  localparam int unsigned XW = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW = $clog2(SCREEN_HEIGHT);
  localparam int unsigned TAB_N = 2 ** xsf_pkg::POS_W;
  localparam logic [XW:0]   W1 = (XW+1)'(SCREEN_WIDTH);
  localparam logic [YW+1:0] H1 = (YW+2)'(SCREEN_HEIGHT);
  localparam logic [YW+1:0] H2 = (YW+2)'(2 * SCREEN_HEIGHT);
  localparam logic [xsf_pkg::ROW_W:0] ROWS_MAX = (xsf_pkg::ROW_W+1)'(MAX_SPRITE_ROWS);

  // coordinate wrap tables, filled at elaboration
  logic [XW-1:0] xmod_tab [TAB_N];
  logic [YW-1:0] ymod_tab [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_tab
    assign xmod_tab[i] = XW'(i % SCREEN_WIDTH);
    assign ymod_tab[i] = YW'(i % SCREEN_HEIGHT);
  end

  // row address of the incoming beat
  logic [XW-1:0]   xs_in;
  logic [YW+1:0]   ysum;
  logic [YW+1:0]   ywrap;
  logic [YW-1:0]   raddr;

  always_comb begin
    xs_in = xmod_tab[in_i.x_pos];
    ysum  = (YW+2)'(ymod_tab[in_i.y_pos]);
    if (in_i.cmd == xsf_pkg::CMD_DRAW) begin
      ysum = ysum + (YW+2)'(in_i.row_offset);
    end
    if (ysum >= H2) begin
      ywrap = ysum - H2;
    end else if (ysum >= H1) begin
      ywrap = ysum - H1;
    end else begin
      ywrap = ysum;
    end
    raddr = ywrap[YW-1:0];
  end

  // latched item
  logic [xsf_pkg::CMD_W-1:0]    cmd_q;
  logic [XW-1:0]                xs_q;
  logic [xsf_pkg::ROW_W-1:0]    row_q;
  logic [xsf_pkg::SPRITE_W-1:0] bits_q;
  logic                         last_q;
  logic                         val_q;
  logic [YW-1:0]                addr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      cmd_q  <= in_i.cmd;
      xs_q   <= xs_in;
      row_q  <= in_i.row_offset;
      bits_q <= in_i.sprite_row;
      last_q <= in_i.last_row;
      val_q  <= in_i.pixel_value;
      addr_q <= raddr;
    end
  end

  // row memory
  logic                    we;
  logic [SCREEN_WIDTH-1:0] wdata;
  logic [SCREEN_WIDTH-1:0] rdata;

  xsf_ram #(
    .WIDTH (SCREEN_WIDTH),
    .DEPTH (SCREEN_HEIGHT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (wdata),
    .re_i    (ctl_i.accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // per-row valid bits: an unwritten or cleared row reads as blank
  logic [SCREEN_HEIGHT-1:0] valid_q;
  logic                     rvalid_q;
  logic                     clear_all;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_all) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      rvalid_q <= valid_q[raddr];
    end
  end

  // sprite mask and row update
  logic [SCREEN_WIDTH-1:0] row_cur;
  logic [SCREEN_WIDTH-1:0] mask;
  logic [XW:0]             pos;
  logic                    row_ok;
  logic                    hit;
  logic                    flag_q, flag_d;
  logic                    flag_we;
  logic                    res_pending;

  always_comb begin
    row_cur = rdata & {SCREEN_WIDTH{rvalid_q}};
    row_ok  = {1'b0, row_q} < ROWS_MAX;
    mask    = '0;
    for (int k = 0; k < xsf_pkg::SPRITE_W; k++) begin
      pos = {1'b0, xs_q} + (XW+1)'(k);
      if (pos >= W1) begin
        pos = pos - W1;
      end
      if (bits_q[xsf_pkg::SPRITE_W-1-k] && row_ok) begin
        mask[pos[XW-1:0]] = 1'b1;
      end
    end
    hit = |(row_cur & mask);

    flag_d    = ((row_q == '0) ? 1'b0 : flag_q) | hit;
    we        = 1'b0;
    wdata     = row_cur;
    clear_all = 1'b0;
    flag_we   = 1'b0;
    case (cmd_q)
      xsf_pkg::CMD_CLEAR: begin
        clear_all = ctl_i.commit;
      end
      xsf_pkg::CMD_DRAW: begin
        wdata   = row_cur ^ mask;
        we      = ctl_i.commit;
        flag_we = ctl_i.commit;
      end
      xsf_pkg::CMD_WRITE: begin
        wdata[xs_q] = val_q;
        we          = ctl_i.commit;
      end
      default: begin
      end
    endcase

    res_pending = (cmd_q == xsf_pkg::CMD_READ) ||
                  ((cmd_q == xsf_pkg::CMD_DRAW) && last_q);
  end

  // collision flag over the rows of a sprite
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (flag_we) begin
      flag_q <= flag_d;
    end
  end

  // output register
  logic out_valid_q;
  logic kind_q;
  logic coll_q;
  logic pix_q;
  logic load_out;

  assign load_out = ctl_i.commit && res_pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (cmd_q == xsf_pkg::CMD_READ) begin
        kind_q <= xsf_pkg::RES_PIXEL;
        coll_q <= 1'b0;
        pix_q  <= row_cur[xs_q];
      end else begin
        kind_q <= xsf_pkg::RES_COLLISION;
        coll_q <= flag_d;
        pix_q  <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.collision   = coll_q;
  assign out_o.pixel_bit   = pix_q;

  // status to the controller
  assign sts_o.result_pending = res_pending;
  assign sts_o.out_hold       = out_valid_q && !out_o.ready;

endmodule

// File: src/xor_sprite_framebuffer.sv
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer
// Monochrome SCREEN_WIDTH x SCREEN_HEIGHT framebuffer with XOR sprite drawing.
// ----------------------------------------------------------------------------
// Command beats arrive on in_i (valid/ready): clear screen, draw one 8-pixel
// sprite row, read one pixel, write one pixel. Coordinates wrap modulo the
// screen size. Result beats leave on out_o: a collision report on the last
// row of a sprite, or the pixel value of a read; clear, write and non-final
// draw rows give no beat.
// Each command is a read-modify-write of one screen row held in a RAM
// with one row per word: the beat is accepted and its row read, then the
// row is written back, and the block takes no new beat until that
// write-back. A result appears on out_o in the cycle after the write-back.
// Reset blanks the whole screen at once through per-row valid bits and
// clears the collision flag; a clear command blanks the screen the same way
// but leaves the collision flag as it is.
// The output register lets one result wait while the next command is taken;
// if a second result is due while the first still waits, the block holds
// that command until the receiver takes the earlier beat.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer #(
  parameter int unsigned SCREEN_WIDTH    = 64,
  parameter int unsigned SCREEN_HEIGHT   = 32,
  parameter int unsigned MAX_SPRITE_ROWS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  xsf_in_if.sink    in_i,
  xsf_out_if.source out_o
);

  xsf_pkg::ctrl_t ctl;
  xsf_pkg::sts_t  sts;

  // sequencer
  xsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // row memory and update logic
  xsf_dpath #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .MAX_SPRITE_ROWS (MAX_SPRITE_ROWS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .ctl_i  (ctl),
    .sts_o  (sts)
  );

  // one command in flight: no new beat right after acceptance
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.accept |=> !in_i.ready)
    else $error("command accepted while another is in flight");

  // a result beat only starts after a commit
  a_out_after_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(ctl.commit))
    else $error("result beat without a committed command");

  // after a commit the block is ready again
  a_ready_after_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.commit |=> in_i.ready)
    else $error("not ready after commit");

endmodule

// File: tb/xor_sprite_framebuffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_sprite_framebuffer_tb
// Self-checking bench for the XOR sprite framebuffer. A directed opener hits
// coordinate wrap, collision reporting and sprite rows that start late. It is
// followed by random sprite runs mixed with pixel reads, writes, clears and
// broken draw rows. An in-bench screen model predicts each result beat, and
// the bench checks every beat in order while both channels stall at random.
// ----------------------------------------------------------------------------
module xor_sprite_framebuffer_tb;

  localparam int unsigned SCR_W    = 64;
  localparam int unsigned SCR_H    = 32;
  localparam int unsigned SPR_ROWS = 16;

  // one command beat
  typedef struct packed {
    xsf_pkg::cmd_e                cmd;
    logic [xsf_pkg::POS_W-1:0]    x_pos;
    logic [xsf_pkg::POS_W-1:0]    y_pos;
    logic [xsf_pkg::ROW_W-1:0]    row_offset;
    logic [xsf_pkg::SPRITE_W-1:0] sprite_row;
    logic                         last_row;
    logic                         pixel_value;
  } fb_cmd_t;

  // one result beat
  typedef struct packed {
    logic result_kind;
    logic collision;
    logic pixel_bit;
  } fb_res_t;

  // screen model plus the queue of result beats still owed by the block
  class frame_scoreboard;
    bit          lit [SCR_W*SCR_H];
    bit          sprite_hit;
    fb_res_t     due_results [$];
    int unsigned mismatches;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned hit_reports;
    int unsigned pixel_reads;

    function new();
      foreach (lit[i]) lit[i] = 1'b0;
      sprite_hit  = 1'b0;
      mismatches  = 0;
      beats_in    = 0;
      beats_out   = 0;
      hit_reports = 0;
      pixel_reads = 0;
    endfunction

    function int unsigned pixel_addr(int unsigned x, int unsigned y);
      return (y % SCR_H) * SCR_W + (x % SCR_W);
    endfunction

    // update the screen for an accepted command and queue any owed beat
    function void take_command(fb_cmd_t c);
      fb_res_t     r;
      int unsigned a;
      beats_in++;
      r = '0;
      case (c.cmd)
        xsf_pkg::CMD_CLEAR: begin
          foreach (lit[i]) lit[i] = 1'b0;
        end
        xsf_pkg::CMD_DRAW: begin
          if (c.row_offset == 0) sprite_hit = 1'b0;
          if (int'(c.row_offset) < SPR_ROWS) begin
            for (int unsigned k = 0; k < xsf_pkg::SPRITE_W; k++) begin
              if (c.sprite_row[xsf_pkg::SPRITE_W-1-k]) begin
                a = pixel_addr(int'(c.x_pos) + k, int'(c.y_pos) + int'(c.row_offset));
                if (lit[a]) sprite_hit = 1'b1;
                lit[a] = ~lit[a];
              end
            end
          end
          if (c.last_row) begin
            r.result_kind = xsf_pkg::RES_COLLISION;
            r.collision   = sprite_hit;
            due_results.push_back(r);
          end
        end
        xsf_pkg::CMD_READ: begin
          r.result_kind = xsf_pkg::RES_PIXEL;
          r.pixel_bit   = lit[pixel_addr(c.x_pos, c.y_pos)];
          due_results.push_back(r);
        end
        default: begin
          lit[pixel_addr(c.x_pos, c.y_pos)] = c.pixel_value;
        end
      endcase
    endfunction

    task report(string what);
      mismatches++;
      $display("%0t ns: mismatch %0d: %s", $realtime, mismatches, what);
    endtask

    // compare one result beat against the oldest owed beat
    task match_result(fb_res_t got);
      fb_res_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected beat kind=%0b collision=%0b pixel=%0b",
                         got.result_kind, got.collision, got.pixel_bit));
        return;
      end
      want = due_results.pop_front();
      beats_out++;
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %0b, expected %0b", got.result_kind, want.result_kind));
      if (got.collision !== want.collision)
        report($sformatf("collision %0b, expected %0b", got.collision, want.collision));
      if (got.pixel_bit !== want.pixel_bit)
        report($sformatf("pixel_bit %0b, expected %0b", got.pixel_bit, want.pixel_bit));
      if (want.result_kind == xsf_pkg::RES_PIXEL) pixel_reads++;
      else if (want.collision) hit_reports++;
    endtask

    task flush_leftovers();
      fb_res_t want;
      while (due_results.size() != 0) begin
        want = due_results.pop_front();
        report($sformatf("beat never arrived: kind=%0b collision=%0b pixel=%0b",
                         want.result_kind, want.collision, want.pixel_bit));
      end
    endtask
  endclass

  logic            clk_i;
  logic            rst_ni;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  frame_scoreboard board;

  xsf_in_if  cmd_bus ();
  xsf_out_if res_bus ();

  xor_sprite_framebuffer #(
    .SCREEN_WIDTH   (SCR_W),
    .SCREEN_HEIGHT  (SCR_H),
    .MAX_SPRITE_ROWS(SPR_ROWS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_bus),
    .out_o (res_bus)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // watchdog
  initial begin
    #(2_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  // command beat monitor
  always @(posedge clk_i) begin
    fb_cmd_t c;
    if (rst_ni && cmd_bus.valid && cmd_bus.ready) begin
      c.cmd         = xsf_pkg::cmd_e'(cmd_bus.cmd);
      c.x_pos       = cmd_bus.x_pos;
      c.y_pos       = cmd_bus.y_pos;
      c.row_offset  = cmd_bus.row_offset;
      c.sprite_row  = cmd_bus.sprite_row;
      c.last_row    = cmd_bus.last_row;
      c.pixel_value = cmd_bus.pixel_value;
      board.take_command(c);
    end
  end

  // result side: check taken beats, stall at random
  always @(posedge clk_i) begin
    fb_res_t got;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got.result_kind = res_bus.result_kind;
      got.collision   = res_bus.collision;
      got.pixel_bit   = res_bus.pixel_bit;
      board.match_result(got);
    end
    if (rst_ni) res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic fb_cmd_t mk(xsf_pkg::cmd_e cmd, int x, int y, int row, int bits,
                                 bit last, bit value);
    fb_cmd_t c;
    c.cmd         = cmd;
    c.x_pos       = x[xsf_pkg::POS_W-1:0];
    c.y_pos       = y[xsf_pkg::POS_W-1:0];
    c.row_offset  = row[xsf_pkg::ROW_W-1:0];
    c.sprite_row  = bits[xsf_pkg::SPRITE_W-1:0];
    c.last_row    = last;
    c.pixel_value = value;
    return c;
  endfunction

  // every field random, callers then pin the ones that matter
  function automatic fb_cmd_t random_cmd();
    return mk(xsf_pkg::cmd_e'($urandom_range(3)), $urandom_range(255),
              $urandom_range(255), $urandom_range(15), $urandom_range(255),
              1'($urandom_range(1)), 1'($urandom_range(1)));
  endfunction

  // present one beat and hold it until taken
  task automatic drive_command(fb_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.cmd         <= c.cmd;
    cmd_bus.x_pos       <= c.x_pos;
    cmd_bus.y_pos       <= c.y_pos;
    cmd_bus.row_offset  <= c.row_offset;
    cmd_bus.sprite_row  <= c.sprite_row;
    cmd_bus.last_row    <= c.last_row;
    cmd_bus.pixel_value <= c.pixel_value;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  task automatic run_directed();
    // blank read, wrapped write and reads with unused fields at max
    drive_command(mk(xsf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
    drive_command(mk(xsf_pkg::CMD_WRITE, 255, 255, 15, 255, 1, 1));
    drive_command(mk(xsf_pkg::CMD_READ, 63, 31, 0, 0, 0, 0));
    drive_command(mk(xsf_pkg::CMD_READ, 255, 255, 15, 255, 1, 1));
    // two-row sprite wrapping in x and y, hits the written pixel
    drive_command(mk(xsf_pkg::CMD_DRAW, 60, 31, 0, 8'hFF, 0, 0));
    drive_command(mk(xsf_pkg::CMD_DRAW, 60, 31, 1, 8'h81, 1, 1));
    drive_command(mk(xsf_pkg::CMD_READ, 3, 0, 0, 0, 0, 0));
    drive_command(mk(xsf_pkg::CMD_DRAW, 60, 31, 0, 8'hFF, 1, 0));
    // empty sprite row: nothing changes, no collision
    drive_command(mk(xsf_pkg::CMD_DRAW, 0, 0, 0, 8'h00, 1, 0));
    // sprite starting late: flag carries over and accumulates
    drive_command(mk(xsf_pkg::CMD_DRAW, 255, 255, 15, 8'h80, 1, 0));
    drive_command(mk(xsf_pkg::CMD_DRAW, 255, 255, 15, 8'h80, 1, 0));
    drive_command(mk(xsf_pkg::CMD_DRAW, 200, 100, 3, 8'h01, 0, 1));
    drive_command(mk(xsf_pkg::CMD_READ, 15, 7, 0, 0, 0, 0));
    drive_command(mk(xsf_pkg::CMD_WRITE, 15, 7, 0, 0, 0, 0));
    drive_command(mk(xsf_pkg::CMD_READ, 15, 7, 0, 0, 0, 0));
    // clear, then draw over a blank screen
    drive_command(mk(xsf_pkg::CMD_CLEAR, 255, 255, 15, 255, 1, 1));
    drive_command(mk(xsf_pkg::CMD_READ, 63, 31, 0, 0, 0, 0));
    drive_command(mk(xsf_pkg::CMD_DRAW, 0, 0, 0, 8'hFF, 1, 1));
    drive_command(mk(xsf_pkg::CMD_DRAW, 0, 0, 0, 8'hAA, 1, 0));
    drive_command(mk(xsf_pkg::CMD_READ, 1, 0, 0, 0, 0, 0));
    drive_command(mk(xsf_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
  endtask

  // mostly well-formed sprites, with reads, writes, rare clears and stray rows
  task automatic run_random(int unsigned count);
    int unsigned done;
    int unsigned pick;
    int unsigned rows;
    fb_cmd_t     c;
    fb_cmd_t     origin;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        rows   = $urandom_range(SPR_ROWS - 1) + 1;
        origin = random_cmd();
        for (int unsigned r = 0; r < rows; r++) begin
          c            = random_cmd();
          c.cmd        = xsf_pkg::CMD_DRAW;
          c.x_pos      = origin.x_pos;
          c.y_pos      = origin.y_pos;
          c.row_offset = r[xsf_pkg::ROW_W-1:0];
          c.last_row   = (r == rows - 1);
          drive_command(c);
          done++;
        end
      end else begin
        c = random_cmd();
        if (pick < 75) c.cmd = xsf_pkg::CMD_READ;
        else if (pick < 87) c.cmd = xsf_pkg::CMD_WRITE;
        else if (pick < 89) c.cmd = xsf_pkg::CMD_CLEAR;
        else c.cmd = xsf_pkg::CMD_DRAW;
        drive_command(c);
        done++;
      end
    end
  endtask

  initial begin
    int unsigned waited;
    rst_ni              = 1'b0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.cmd         = xsf_pkg::CMD_CLEAR;
    cmd_bus.x_pos       = '0;
    cmd_bus.y_pos       = '0;
    cmd_bus.row_offset  = '0;
    cmd_bus.sprite_row  = '0;
    cmd_bus.last_row    = 1'b0;
    cmd_bus.pixel_value = 1'b0;
    res_bus.ready       = 1'b0;
    board               = new();
    send_idle_pct       = 37;
    recv_idle_pct       = 80;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(450);
    send_idle_pct = 80;
    recv_idle_pct = 37;
    run_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(450);
    cmd_bus.valid <= 1'b0;

    // drain owed beats, then let the pipeline settle
    waited = 0;
    while (board.due_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (10) @(posedge clk_i);
    board.flush_leftovers();

    $display("covered %0d command beats, %0d result beats checked",
             board.beats_in, board.beats_out);
    $display("  %0d pixel reads, %0d sprites reported a collision",
             board.pixel_reads, board.hit_reports);
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
